### rtl/core/lru_key_value_cache_top_assert.svh
// assertion macros for the lru key/value cache
`ifndef LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH

// clocked check, held off while reset is asserted
`define LKVC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// clocked check that also holds during reset
`define LKVC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/lkvc_pkg.sv
// shared types and constants for the lru key/value cache
package lkvc_pkg;

	// number of cells in the chain
	localparam int ENTRIES = 16;
	// occupancy counter width, holds 0..ENTRIES
	localparam int CNT_W = $clog2(ENTRIES + 1);
	// capacity register width
	localparam int CAP_W = 5;
	// width for capacity and occupancy compares
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam int KEY_W = 32;
	localparam int VAL_W = 32;

	// register indexes
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// operation codes
	localparam logic OP_GET = 1'b0;
	localparam logic OP_SET = 1'b1;

	// value returned by a get miss
	localparam logic [VAL_W-1:0] MISS_VALUE = '1;

	// per-cell update control
	typedef struct packed {
		logic load;     // take key and value from the neighbor
		logic set_vld;  // rewrite the valid bit
		logic vld_d;    // new valid bit
	} cell_ctrl_t;

endpackage

### rtl/core/lkvc_cell.sv
// one cache slot: key, value and valid bit, with its own key compare
module lkvc_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lkvc_pkg::cell_ctrl_t       ctrl,
	input  logic [lkvc_pkg::KEY_W-1:0] key_in,
	input  logic [lkvc_pkg::VAL_W-1:0] value_in,
	input  logic [lkvc_pkg::KEY_W-1:0] cmp_key,
	output logic [lkvc_pkg::KEY_W-1:0] key,
	output logic [lkvc_pkg::VAL_W-1:0] value,
	output logic                       valid,
	output logic                       match
);
	import lkvc_pkg::*;

	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;
	logic             valid_q;

	// payload shifts in from the neighbor, no reset needed
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			key_q   <= key_in;
			value_q <= value_in;
		end
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.set_vld) begin
			valid_q <= ctrl.vld_d;
		end
	end

	assign key   = key_q;
	assign value = value_q;
	assign valid = valid_q;
	assign match = valid_q && (key_q == cmp_key);

endmodule

### rtl/core/lru_key_value_cache_top.sv
// lru key/value cache: chain of slot cells, recency order by position, apb config
// flow: the accept edge registers the request word; in the look state the parallel key
//   compare, the chain shift and the result register update happen together at the commit
// a new word is accepted only in the idle state, once the previous word has committed
// reset: all valid bits and occupancy cleared at once, capacity back to 16, no clearing pass
// a stalled output holds the finished word and blocks the next commit
module lru_key_value_cache_top (
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // key [31:0], value [63:32]
	input  logic        s_tuser,   // op
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // read_value [31:0]
	output logic [1:0]  m_tuser    // hit [0], evicted [1]
);
	import lkvc_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_LOOK = 1'b1;

	logic             state_q;
	logic [CAP_W-1:0] capacity_q;
	logic [CNT_W-1:0] occupancy_q;

	logic             op_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;

	logic             m_valid_q;
	logic [VAL_W-1:0] m_value_q;
	logic             m_hit_q;
	logic             m_evict_q;

	logic [KEY_W-1:0] cell_key [ENTRIES];
	logic [VAL_W-1:0] cell_value [ENTRIES];
	logic [ENTRIES-1:0] cell_valid;
	logic [ENTRIES-1:0] cell_match;
	logic [ENTRIES-1:0] match_before;  // some match strictly below this cell
	logic [ENTRIES-1:0] first_hit;
	cell_ctrl_t         cell_ctrl [ENTRIES];

	logic             present;
	logic [VAL_W-1:0] hit_value;
	logic [CMP_W-1:0] eff_cap;
	logic [CMP_W-1:0] occ_ext;
	logic             full;
	logic [CMP_W-1:0] keep;
	logic [CMP_W-1:0] new_occ;
	logic             commit;
	logic             wr_cap;

	// config write and read
	assign pready = 1'b1;
	assign wr_cap = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (wr_cap) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(capacity_q) : 32'd0;

	// sequencer: accept, then compare and shift
	assign s_tready = (state_q == ST_IDLE);
	assign commit   = (state_q == ST_LOOK) && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (s_tvalid) state_q <= ST_LOOK;
				ST_LOOK: if (commit) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request word
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q    <= s_tuser;
			key_q   <= s_tdata[KEY_W-1:0];
			value_q <= s_tdata[KEY_W+VAL_W-1:KEY_W];
		end
	end

	// first matching cell and its value
	always_comb begin
		match_before[0] = 1'b0;
		for (int i = 1; i < ENTRIES; i++) begin
			match_before[i] = match_before[i-1] || cell_match[i-1];
		end
		first_hit = cell_match & ~match_before;
		hit_value = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_value = hit_value | ({VAL_W{first_hit[i]}} & cell_value[i]);
		end
	end
	assign present = |cell_match;

	// insert bookkeeping with clamped capacity
	always_comb begin
		if (capacity_q == '0) begin
			eff_cap = CMP_W'(1);
		end else if (CMP_W'(capacity_q) > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = CMP_W'(capacity_q);
		end
		occ_ext = CMP_W'(occupancy_q);
		full    = (occ_ext >= eff_cap);
		keep    = full ? (eff_cap - CMP_W'(1)) : occ_ext;
		new_occ = keep + CMP_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupancy_q <= '0;
		end else if (commit && (op_q == OP_SET) && !present) begin
			occupancy_q <= new_occ[CNT_W-1:0];
		end
	end

	// cell chain, cell 0 is most recent
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		logic [KEY_W-1:0] nb_key;
		logic [VAL_W-1:0] nb_value;

		if (i == 0) begin : g_head
			assign nb_key   = key_q;
			assign nb_value = value_q;
		end else begin : g_link
			assign nb_key   = cell_key[i-1];
			assign nb_value = cell_value[i-1];
		end

		// on a set, a hit shifts cells up to the hit, a miss shifts up to the kept count
		always_comb begin
			cell_ctrl[i].load    = commit && (op_q == OP_SET) &&
				(present ? !match_before[i] : (CMP_W'(i) <= keep));
			cell_ctrl[i].set_vld = commit && (op_q == OP_SET) && !present;
			cell_ctrl[i].vld_d   = (CMP_W'(i) < new_occ);
		end

		lkvc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (cell_ctrl[i]),
			.key_in   (nb_key),
			.value_in (nb_value),
			.cmp_key  (key_q),
			.key      (cell_key[i]),
			.value    (cell_value[i]),
			.valid    (cell_valid[i]),
			.match    (cell_match[i])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (commit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			m_hit_q   <= present;
			m_evict_q <= (op_q == OP_SET) && !present && full;
			if (op_q == OP_GET) begin
				m_value_q <= present ? hit_value : MISS_VALUE;
			end else begin
				m_value_q <= '0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_value_q;
	assign m_tuser  = {m_evict_q, m_hit_q};

	`include "lru_key_value_cache_top_assert.svh"

	// valid cells form a prefix of the chain
	`LKVC_ASSERT(a_valid_prefix, ((cell_valid & (cell_valid + 1'b1)) == '0), "valid bits not a prefix")
	// occupancy counts the valid cells
	`LKVC_ASSERT(a_occ_count, ($countones(cell_valid) == int'(occupancy_q)), "occupancy mismatch")
	// keys are unique, so at most one cell matches
	`LKVC_ASSERT(a_single_match, ((state_q != ST_LOOK) || $onehot0(cell_match)), "duplicate key")
	// a commit returns the sequencer to idle with a result pending
	`LKVC_ASSERT(a_commit_idle, (commit |=> ((state_q == ST_IDLE) && m_valid_q)), "commit lost")
	// occupancy never exceeds the chain length
	`LKVC_ASSERT(a_occ_bound, (int'(occupancy_q) <= ENTRIES), "occupancy overflow")

endmodule

### tb/sv/lru_key_value_cache_checker.sv
`timescale 1ns / 1ps
// scoreboard for the lru key/value cache: tracks the cache contents and checks every result word
module lru_key_value_cache_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,   // key [31:0], value [63:32]
	input  logic        s_tuser,   // op
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // read_value [31:0]
	input  logic [1:0]  m_tuser,   // hit [0], evicted [1]
	output int          errors,
	output int          outstanding,
	output int          hits_seen,
	output int          evictions_seen
);
	import lkvc_pkg::*;

	localparam logic [2:0] CAP_ADDR = 3'(4 * int'(REG_CAPACITY));

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] read_value;
		logic             evicted;
	} cache_reply_t;

	// shadow of the cache: slot 0 most recent
	logic [KEY_W-1:0] shadow_key [ENTRIES];
	logic [VAL_W-1:0] shadow_val [ENTRIES];
	int               shadow_fill;
	logic [CAP_W-1:0] shadow_cap;
	cache_reply_t     reply_q [$];

	// work out the reply to one request and update the shadow contents
	task automatic cache_lookup(input logic op, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v, output cache_reply_t r);
		int found;
		int lim;
		int keep;
		found = -1;
		for (int i = 0; i < shadow_fill; i++)
			if (found < 0 && shadow_key[i] == k)
				found = i;
		r.hit = (found >= 0);
		r.read_value = '0;
		r.evicted = 1'b0;
		if (op == OP_GET) begin
			r.read_value = (found >= 0) ? shadow_val[found] : MISS_VALUE;
		end else begin
			if (found >= 0) begin
				keep = found;
			end else begin
				// capacity 0 behaves as 1, anything above the slot count as full size
				lim = (shadow_cap == 0) ? 1 : (shadow_cap > ENTRIES) ? ENTRIES : int'(shadow_cap);
				keep = shadow_fill;
				if (shadow_fill >= lim) begin
					r.evicted = 1'b1;
					keep = lim - 1;
				end
				shadow_fill = keep + 1;
			end
			for (int i = keep; i > 0; i--) begin
				if (i < ENTRIES) begin
					shadow_key[i] = shadow_key[i-1];
					shadow_val[i] = shadow_val[i-1];
				end
			end
			shadow_key[0] = k;
			shadow_val[0] = v;
		end
	endtask

	// watch config, result and request channels
	always @(posedge clk or negedge arst_n) begin : track
		cache_reply_t want;
		cache_reply_t got;
		if (!arst_n) begin
			shadow_fill = 0;
			shadow_cap = CAP_RESET;
			reply_q.delete();
			errors = 0;
			hits_seen = 0;
			evictions_seen = 0;
			outstanding <= 0;
		end else begin
			// register access
			if (psel && penable && pready && paddr == CAP_ADDR) begin
				if (pwrite) begin
					shadow_cap = pwdata[CAP_W-1:0];
				end else if (prdata !== {{(32-CAP_W){1'b0}}, shadow_cap}) begin
					$error("capacity_in_use readback: expected %0d, actual %h", shadow_cap, prdata);
					errors++;
				end
			end
			// result word against the oldest expectation
			if (m_tvalid && m_tready) begin
				got.hit = m_tuser[0];
				got.evicted = m_tuser[1];
				got.read_value = m_tdata;
				if (reply_q.size() == 0) begin
					$error("unexpected result word: hit %b read_value %h evicted %b",
						got.hit, got.read_value, got.evicted);
					errors++;
				end else begin
					want = reply_q.pop_front();
					if (got.hit !== want.hit) begin
						$error("hit: expected %b, actual %b", want.hit, got.hit);
						errors++;
					end
					if (got.read_value !== want.read_value) begin
						$error("read_value: expected %h, actual %h", want.read_value, got.read_value);
						errors++;
					end
					if (got.evicted !== want.evicted) begin
						$error("evicted: expected %b, actual %b", want.evicted, got.evicted);
						errors++;
					end
				end
			end
			// accepted request word
			if (s_tvalid && s_tready) begin
				cache_lookup(s_tuser, s_tdata[31:0], s_tdata[63:32], want);
				hits_seen += want.hit;
				evictions_seen += want.evicted;
				reply_q.push_back(want);
			end
			outstanding <= reply_q.size();
		end
	end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// top of the lru key/value cache testbench: clock, reset, stimulus and verdict
module testbench;
	import lkvc_pkg::*;

	localparam logic [2:0] CAP_ADDR = 3'(4 * int'(REG_CAPACITY));
	localparam int STALL_LIMIT = 4000;
	localparam int SEG_ITEMS = 65;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        s_tvalid, s_tready;
	logic [63:0] s_tdata;   // key [31:0], value [63:32]
	logic        s_tuser;   // op
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;   // read_value [31:0]
	logic [1:0]  m_tuser;   // hit [0], evicted [1]

	int errors, outstanding, hits_seen, evictions_seen;
	int src_idle_pct = 7;
	int sink_idle_pct = 73;
	int n_items = 0;
	int n_caps = 0;
	int quiet_cycles = 0;
	int cap_plan [12] = '{16, 1, 7, 0, 31, 3, 17, 16, 2, 9, 15, 4};

	lru_key_value_cache_top dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	lru_key_value_cache_checker scoreboard (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.errors(errors), .outstanding(outstanding),
		.hits_seen(hits_seen), .evictions_seen(evictions_seen)
	);

	always #1 clk = ~clk;

	// result side back-pressure
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
	end

	// watchdog on cycles with no accepted word, result or config access
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(psel && penable && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one request word, with a random gap ahead of it
	task automatic send_req(input logic op, input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v);
		if ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < src_idle_pct)
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {v, k};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		n_items++;
	endtask

	// hold requests until every reply is back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write the capacity register, then read it back
	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAP_ADDR;
		pwdata <= ($urandom() & ~32'h1F) | 32'(cap);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		n_caps++;
	endtask

	initial begin
		logic [KEY_W-1:0] pool [20];
		int psize;
		int lim;
		logic [KEY_W-1:0] k;
		logic op;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_GET;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme keys and values at reset capacity
		send_req(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
		send_req(OP_SET, 32'h8000_0000, 32'h7FFF_FFFF);
		send_req(OP_SET, 32'h7FFF_FFFF, 32'h8000_0000);
		send_req(OP_SET, 32'h0000_0000, 32'h0000_0000);
		send_req(OP_SET, 32'hFFFF_FFFF, 32'h1234_5678);
		send_req(OP_GET, 32'h8000_0000, 32'h0000_0000);
		// update of a present key, stored value equal to the miss value
		send_req(OP_SET, 32'h8000_0000, 32'hFFFF_FFFF);
		send_req(OP_GET, 32'h8000_0000, 32'h5555_5555);
		send_req(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		send_req(OP_GET, 32'h0000_1234, 32'hAAAA_AAAA);
		// capacity dropped below the current fill
		drain();
		set_capacity(5'd2);
		send_req(OP_SET, 32'hA5A5_A5A5, 32'h0F0F_0F0F);
		send_req(OP_GET, 32'h8000_0000, 32'h0000_0000);
		send_req(OP_GET, 32'h0000_0000, 32'h0000_0000);
		send_req(OP_SET, 32'h8000_0000, 32'h0000_0001);
		// single entry store
		drain();
		set_capacity(5'd1);
		send_req(OP_SET, 32'h5A5A_5A5A, 32'hF0F0_F0F0);
		send_req(OP_GET, 32'h5A5A_5A5A, 32'h0000_0000);
		send_req(OP_GET, 32'h8000_0000, 32'h0000_0000);
		// zero capacity acts as one
		drain();
		set_capacity(5'd0);
		send_req(OP_SET, 32'h0000_0001, 32'h0000_0001);
		send_req(OP_SET, 32'h0000_0001, 32'h0000_0002);
		send_req(OP_GET, 32'h0000_0001, 32'h0000_0000);
		// over-range capacity acts as full size
		drain();
		set_capacity(5'd31);
		send_req(OP_SET, 32'hDEAD_BEEF, 32'hCAFE_F00D);
		send_req(OP_GET, 32'h0000_0001, 32'h0000_0000);

		// random: key pool a little larger than the capacity, so hits and evictions mix
		for (int phase = 0; phase < 3; phase++) begin
			for (int seg = 0; seg < 4; seg++) begin
				drain();
				src_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 73 : 0;
				sink_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 7 : 0;
				set_capacity(CAP_W'(cap_plan[phase*4 + seg]));
				lim = (cap_plan[phase*4 + seg] == 0) ? 1 :
					(cap_plan[phase*4 + seg] > ENTRIES) ? ENTRIES : cap_plan[phase*4 + seg];
				psize = lim + $urandom_range(0, 4);
				for (int i = 0; i < 20; i++)
					pool[i] = $urandom();
				for (int n = 0; n < SEG_ITEMS; n++) begin
					k = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, psize - 1)] : $urandom();
					op = 1'($urandom_range(0, 1));
					send_req(op, k, $urandom());
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);
		$display("covered %0d requests, %0d hits and %0d evictions, over %0d capacity writes",
			n_items, hits_seen, evictions_seen, n_caps);
		$display("capacities 0, 1, 16, 17 and 31 included, under three back-pressure profiles");
		if (errors == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_cell.sv
rtl/core/lru_key_value_cache_top.sv
tb/sv/lru_key_value_cache_checker.sv
tb/sv/testbench.sv
